@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the remote code matcher.
// Self-contained; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge while reset is low.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lrcm_pkg.sv @@
// Shared types and constants of the learning remote code matcher.
// No dependencies; imported by the match logic and the top level.
package lrcm_pkg;

   localparam int CODE_W    = 24;
   localparam int BITS_W    = 6;
   localparam int REPS_W    = 8;
   localparam int TIME_W    = 32;
   localparam int HOLD_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int INDEX_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [HOLD_W-1:0] HOLD_OFF_RESET = 8'd5;
   localparam logic [BITS_W-1:0] BIT_COUNT_RESET = 6'd24;
   localparam logic [REPS_W-1:0] REPEATS_RESET = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_OFF  = 2'd0,
      CSR_BIT_COUNT = 2'd1,
      CSR_REPEATS   = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOTIFY     = 3'd0,
      ST_SUPPRESSED = 3'd1,
      ST_LEARNED    = 3'd2,
      ST_UNKNOWN    = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   // Outcome of comparing one frame code against the table.
   typedef struct packed {
      logic hit;    // a valid entry holds the code
      logic fire;   // the hit entry is past its hold-off
   } match_type;

endpackage

@@ hw/rtl/learning_remote_code_matcher.sv @@
// Learning remote code matcher: one input register stage, the table compare
// and an output register. Uses lrcm_pkg, lrcm_match and assert_macros.svh.
//
// Each transaction on the request side carries one decoded radio frame. A
// frame whose bit count or repeat count differs from the programmed values
// is dropped and yields no response. An accepted frame is compared with
// every learned entry at once; a hit reports notify and restamps the entry
// when its last fire time plus the hold-off lies strictly before the frame's
// time, and suppressed otherwise. An unknown code is learned into the next
// free entry (last fire time zero) while the learn button is held and there
// is room; otherwise it reports unknown or table full. Each frame passes
// through the input register and then the output register, and a new
// frame is taken every cycle as long as the response side keeps up; the
// combinational table compare and its registered update set that rate.
// The table is emptied at reset by clearing the entry count, so there is no
// clearing pass. Configuration writes belong in idle periods.
`include "assert_macros.svh"

module learning_remote_code_matcher import lrcm_pkg::*; #(
   parameter int TABLE_ENTRIES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request side.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_code[23:0], frame_bits[29:24], frame_repeats[37:30],
   // now_seconds[69:38], zero fill [71:70]
   input  logic [71:0]           req_tdata,
   // learn_pressed[0]
   input  logic                  req_tuser,
   // Response side.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_index[1:0], zero fill [7:2]
   output logic [7:0]            rsp_tdata,
   // status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

   // Configuration registers.
   logic [HOLD_W-1:0] hold_off_ff,  hold_off_in;
   logic [BITS_W-1:0] bit_count_ff, bit_count_in;
   logic [REPS_W-1:0] repeats_ff,   repeats_in;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [CODE_W-1:0] code_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [REPS_W-1:0] reps_ff;
   logic              learn_ff;
   logic [TIME_W-1:0] now_ff;

   // Code table. Entries at or above the count are never looked at.
   logic [CODE_W-1:0] code_table_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0] last_time_ff  [TABLE_ENTRIES];
   logic [CNT_W-1:0]  count_ff, count_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff,    status_in;
   logic [INDEX_W-1:0] index_ff,    index_in;

   match_type         match;
   logic [IDX_W-1:0]  hit_index;
   logic              frame_ok;
   logic              advance;
   logic              do_fire;
   logic              do_learn;
   logic [IDX_W-1:0]  learn_index;

   lrcm_match #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W(IDX_W),
      .CNT_W(CNT_W)
   ) u_match (
      .code(code_ff),
      .now(now_ff),
      .hold_off(hold_off_ff),
      .count(count_ff),
      .code_table(code_table_ff),
      .last_time(last_time_ff),
      .result(match),
      .hit_index(hit_index)
   );

   // A dropped frame needs no room in the output register, so it always
   // leaves the input stage.
   assign frame_ok    = (bits_ff == bit_count_ff) && (reps_ff == repeats_ff);
   assign advance     = in_valid_ff && (!frame_ok || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign learn_index = count_ff[IDX_W-1:0];
   assign do_fire     = advance && frame_ok && match.hit && match.fire;
   assign do_learn    = advance && frame_ok && !match.hit && learn_ff &&
                        (count_ff < CNT_FULL);

   always_comb begin
      hold_off_in  = hold_off_ff;
      bit_count_in = bit_count_ff;
      repeats_in   = repeats_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HOLD_OFF:  hold_off_in  = csr_wdata[HOLD_W-1:0];
            CSR_BIT_COUNT: bit_count_in = csr_wdata[BITS_W-1:0];
            CSR_REPEATS:   repeats_in   = csr_wdata[REPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && frame_ok) begin
         rsp_valid_in = 1'b1;
         index_in     = '0;
         if (match.hit) begin
            status_in = match.fire ? ST_NOTIFY : ST_SUPPRESSED;
            index_in  = INDEX_W'(hit_index);
         end else if (!learn_ff) begin
            status_in = ST_UNKNOWN;
         end else if (count_ff >= CNT_FULL) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_LEARNED;
            index_in  = INDEX_W'(learn_index);
            count_in  = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_off_ff  <= HOLD_OFF_RESET;
         bit_count_ff <= BIT_COUNT_RESET;
         repeats_ff   <= REPEATS_RESET;
         in_valid_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_off_ff  <= hold_off_in;
         bit_count_ff <= bit_count_in;
         repeats_ff   <= repeats_in;
         in_valid_ff  <= in_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         code_ff  <= req_tdata[23:0];
         bits_ff  <= req_tdata[29:24];
         reps_ff  <= req_tdata[37:30];
         now_ff   <= req_tdata[69:38];
         learn_ff <= req_tuser;
      end
      if (advance && frame_ok) begin
         status_ff <= status_in;
         index_ff  <= index_in;
      end
      if (do_fire) begin
         last_time_ff[hit_index] <= now_ff;
      end
      if (do_learn) begin
         code_table_ff[learn_index] <= code_ff;
         last_time_ff[learn_index]  <= '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(8 - INDEX_W){1'b0}}, index_ff};

   // The learned count never runs past the table size.
   `ASSERT_AT(a_count_bound, clock, reset, count_ff <= CNT_FULL, "entry count exceeds table size")
   // A learned entry adds exactly one to the count.
   `ASSERT_NEXT(a_learn_count, clock, reset, do_learn, count_ff == $past(count_ff) + 1'b1, "learn did not bump count")
   // Table full is only reported once every entry is taken.
   `ASSERT_AT(a_full_count, clock, reset, !(rsp_valid_ff && status_ff == ST_FULL) || count_ff == CNT_FULL, "full reported with room left")
   // Unknown and full responses carry entry index zero.
   `ASSERT_AT(a_miss_index, clock, reset, !(rsp_valid_ff && (status_ff == ST_UNKNOWN || status_ff == ST_FULL)) || index_ff == '0, "miss response has nonzero index")

endmodule

@@ hw/rtl/lrcm_match.sv @@
// Table compare of the learning remote code matcher: one comparator and one
// hold-off check per entry, then a first-match priority pick. Uses lrcm_pkg.
module lrcm_match import lrcm_pkg::*; #(
   parameter int TABLE_ENTRIES = 4,
   parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic [CODE_W-1:0] code,
   input  logic [TIME_W-1:0] now,
   input  logic [HOLD_W-1:0] hold_off,
   input  logic [CNT_W-1:0]  count,
   input  logic [CODE_W-1:0] code_table [TABLE_ENTRIES],
   input  logic [TIME_W-1:0] last_time  [TABLE_ENTRIES],
   output match_type         result,
   output logic [IDX_W-1:0]  hit_index
);

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [TABLE_ENTRIES-1:0] due_vec;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_entry
      logic [TIME_W:0] due;
      assign due        = {1'b0, last_time[k]} + {{(TIME_W + 1 - HOLD_W){1'b0}}, hold_off};
      assign hit_vec[k] = (CNT_W'(k) < count) && (code_table[k] == code);
      assign due_vec[k] = due < {1'b0, now};
   end

   // Codes are never stored twice, but the lowest entry still wins.
   always_comb begin
      result    = '0;
      hit_index = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            result.hit  = 1'b1;
            result.fire = due_vec[k];
            hit_index   = IDX_W'(k);
         end
      end
   end

endmodule

@@ test/learning_remote_code_matcher_test.sv @@
// Self-checking testbench for learning_remote_code_matcher: directed frames, then random ones.
// Needs lrcm_pkg and the RTL only; a scoreboard class predicts and checks every response.
module learning_remote_code_matcher_test;
   import lrcm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = 4;
   // Index past the end of the register list; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 150000;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int STALL_CYCLES = 300;

   // One expected response: the status and the table entry it names.
   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   index;
   } response_type;

   // Mirrors the block: its registers, its code table and the responses still
   // owed. Frames are noted when the request transaction completes, and each
   // response transaction is checked against the oldest owed response.
   class code_match_tracker;
      logic [HOLD_W-1:0]  hold_off;
      logic [BITS_W-1:0]  bit_count;
      logic [REPS_W-1:0]  repeats;
      logic [CODE_W-1:0]  codes [TABLE_ENTRIES];
      logic [TIME_W-1:0]  stamps [TABLE_ENTRIES];
      int unsigned        learned;
      response_type       owed [$];
      int                 errors;
      int                 dropped;
      int                 answered;
      int                 tally [5];

      function new();
         hold_off = HOLD_OFF_RESET;
         bit_count = BIT_COUNT_RESET;
         repeats = REPEATS_RESET;
         learned = 0;
         errors = 0;
         dropped = 0;
         answered = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HOLD_OFF:  hold_off = data[HOLD_W-1:0];
            CSR_BIT_COUNT: bit_count = data[BITS_W-1:0];
            CSR_REPEATS:   repeats = data[REPS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_frame(logic [CODE_W-1:0] code, logic [BITS_W-1:0] bits,
                               logic [REPS_W-1:0] reps, logic learn, logic [TIME_W-1:0] now);
         response_type r;
         int hit;
         logic [TIME_W:0] due;
         if (bits != bit_count || reps != repeats) begin
            dropped++;
            return;
         end
         hit = -1;
         for (int k = 0; k < learned; k++)
            if (hit < 0 && codes[k] == code) hit = k;
         if (hit >= 0) begin
            // One extra bit keeps the sum from wrapping near the top of time.
            due = {1'b0, stamps[hit]} + {{(TIME_W+1-HOLD_W){1'b0}}, hold_off};
            if (due < {1'b0, now}) begin
               stamps[hit] = now;
               r.status = ST_NOTIFY;
            end else begin
               r.status = ST_SUPPRESSED;
            end
            r.index = hit[INDEX_W-1:0];
         end else if (!learn) begin
            r.status = ST_UNKNOWN;
            r.index = '0;
         end else if (learned >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
            r.index = '0;
         end else begin
            codes[learned] = code;
            stamps[learned] = '0;
            r.status = ST_LEARNED;
            r.index = learned[INDEX_W-1:0];
            learned++;
         end
         answered++;
         owed.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [7:0] data);
         response_type r;
         if (owed.size() == 0) begin
            $display("%0t: response with none owed: expected nothing, got status %0d index %0d",
                     $time, status, data[INDEX_W-1:0]);
            errors++;
            return;
         end
         r = owed.pop_front();
         if (status !== r.status) begin
            $display("%0t: status expected %0d (%s), got %0d",
                     $time, r.status, r.status.name(), status);
            errors++;
         end
         if (data[INDEX_W-1:0] !== r.index) begin
            $display("%0t: entry_index expected %0d, got %0d", $time, r.index, data[INDEX_W-1:0]);
            errors++;
         end
         if (r.status <= ST_FULL) tally[r.status]++;
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // frame_code[23:0], frame_bits[29:24], frame_repeats[37:30],
   // now_seconds[69:38], zero fill [71:70]
   logic [71:0]            req_tdata = '0;
   // learn_pressed[0]
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // entry_index[1:0], zero fill [7:2]
   logic [7:0]             rsp_tdata;
   // status[2:0]
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   code_match_tracker tracker = new();

   // When clear, neither side inserts idle cycles.
   bit idling = 1'b1;
   // Set once by the stimulus; the response side then stalls for a long stretch.
   bit pressure_armed = 1'b0;
   int cycle_count = 0;
   int frames_sent = 0;

   learning_remote_code_matcher #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offers one frame, with random idle cycles ahead of it, and waits until the
   // request transaction completes. The frame is noted at that edge. Valid is
   // only lowered in idle cycles, so it never gets two updates in one step.
   task automatic send_frame(input logic [CODE_W-1:0] code, input logic [BITS_W-1:0] bits,
                             input logic [REPS_W-1:0] reps, input logic learn,
                             input logic [TIME_W-1:0] now);
      while (idling && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, now, reps, bits, code};
      req_tuser <= learn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_frame(code, bits, reps, learn, now);
      frames_sent++;
   endtask

   // A single register write; the caller lowers the write enable afterwards.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   // Registers only change while the block is idle. Dropped frames give no
   // response, so the task also idles after the last owed response to let
   // any of them drain out of the input register.
   task automatic program_registers(input logic [7:0] hold, input logic [7:0] bits,
                                    input logic [7:0] reps, input bit touch_spare);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_csr(CSR_HOLD_OFF, hold);
      write_csr(CSR_BIT_COUNT, bits);
      write_csr(CSR_REPEATS, reps);
      if (touch_spare) write_csr(CSR_SPARE, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed frames for codes already in the table, with the time
   // placed right around each entry's hold-off boundary so that notify and
   // suppressed both occur often. The rest are new codes, random times, and
   // frames with a wrong bit or repeat count.
   task automatic random_frame();
      logic [CODE_W-1:0] code;
      logic [BITS_W-1:0] bits;
      logic [REPS_W-1:0] reps;
      logic [TIME_W-1:0] now;
      int k;
      bits = tracker.bit_count;
      reps = tracker.repeats;
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 2))
            0: bits = 6'($urandom);
            1: reps = 8'($urandom);
            default: begin
               bits = 6'($urandom);
               reps = 8'($urandom);
            end
         endcase
      end
      code = 24'($urandom);
      now = $urandom;
      if (tracker.learned > 0 && $urandom_range(0, 99) < 70) begin
         k = $urandom_range(0, tracker.learned - 1);
         code = tracker.codes[k];
         if ($urandom_range(0, 99) < 80)
            now = tracker.stamps[k] + {24'b0, tracker.hold_off} - 32'd2
                  + 32'($urandom_range(0, 4));
      end
      send_frame(code, bits, reps, 1'($urandom), now);
   endtask

   task automatic random_phase(input int count);
      int start;
      start = tracker.answered;
      while (tracker.answered - start < count) random_frame();
   endtask

   // Response side: checks each completed response transaction, then picks
   // the ready level for the next cycle. The long stall is counted here.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tuser, rsp_tdata);
         if (pressure_armed) begin
            pressure_armed = 1'b0;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!idling) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 21);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("learning_remote_code_matcher: mismatch");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: hold-off 5, 24 bits, 3 repeats. The first entry sees
      // unknown, learned, suppressed at the boundary, notify, then suppressed.
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b0, 32'hFFFFFFFF);
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b1, 32'd0);
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b0, 32'd5);
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b0, 32'd6);
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b1, 32'd6);
      // Wrong bit count, wrong repeat count, and both wrong: all dropped.
      send_frame(24'h000000, 6'd63, 8'd3, 1'b1, 32'd1);
      send_frame(24'h000000, 6'd24, 8'd255, 1'b1, 32'd1);
      send_frame(24'h000000, 6'd0, 8'd0, 1'b1, 32'd1);
      // Fill the table; entry one is stamped near the top of time.
      send_frame(24'h000000, 6'd24, 8'd3, 1'b1, 32'd1);
      send_frame(24'h000000, 6'd24, 8'd3, 1'b0, 32'hFFFFFF80);
      send_frame(24'h123456, 6'd24, 8'd3, 1'b1, 32'd2);
      send_frame(24'hA5C3E1, 6'd24, 8'd3, 1'b1, 32'd3);
      // Table full with the button held, then the same code without it.
      send_frame(24'h5A3C1E, 6'd24, 8'd3, 1'b1, 32'd4);
      send_frame(24'h5A3C1E, 6'd24, 8'd3, 1'b0, 32'd4);
      send_frame(24'h123456, 6'd24, 8'd3, 1'b0, 32'hFFFFFF85);

      // Largest hold-off and bit count, zero repeats. The bit count write
      // carries ones above its six bits, and the spare index is written too.
      program_registers(8'hFF, 8'hFF, 8'h00, 1'b1);
      // A 32-bit sum would wrap to 0x7F here and fire; the widened one must not.
      send_frame(24'h000000, 6'd63, 8'd0, 1'b0, 32'h00000100);
      send_frame(24'hA5C3E1, 6'd63, 8'd0, 1'b0, 32'd255);
      send_frame(24'hA5C3E1, 6'd63, 8'd0, 1'b0, 32'd256);
      send_frame(24'hFFFFFF, 6'd24, 8'd3, 1'b0, 32'd500);

      // Zero hold-off, smallest bit count, most repeats.
      program_registers(8'h00, 8'h01, 8'hFF, 1'b0);
      send_frame(24'hFFFFFF, 6'd1, 8'd255, 1'b0, 32'd6);
      send_frame(24'hFFFFFF, 6'd1, 8'd255, 1'b0, 32'd7);

      // Random phases. The first runs with no idling on either side; the
      // second stalls the response side long enough to back up the input.
      program_registers(8'h05, 8'hD8, 8'h03, 1'b0);
      idling = 1'b0;
      random_phase(ITEMS_PER_PHASE);
      idling = 1'b1;

      program_registers(8'hFF, 8'h3F, 8'h00, 1'b1);
      pressure_armed = 1'b1;
      random_phase(ITEMS_PER_PHASE);

      program_registers(8'h00, 8'h01, 8'hFF, 1'b0);
      random_phase(ITEMS_PER_PHASE);

      program_registers(8'($urandom), 8'($urandom_range(1, 63)), 8'($urandom), 1'b1);
      random_phase(ITEMS_PER_PHASE);

      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run sent %0d frames: %0d dropped by the count filters, %0d answered.",
               frames_sent, tracker.dropped, tracker.answered);
      $display("Responses: notify %0d, suppressed %0d, learned %0d, unknown %0d, full %0d.",
               tracker.tally[ST_NOTIFY], tracker.tally[ST_SUPPRESSED],
               tracker.tally[ST_LEARNED], tracker.tally[ST_UNKNOWN], tracker.tally[ST_FULL]);
      if (tracker.errors == 0) begin
         $display("learning_remote_code_matcher: match");
      end else begin
         $display("learning_remote_code_matcher: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lrcm_pkg.sv
hw/rtl/lrcm_match.sv
hw/rtl/learning_remote_code_matcher.sv
test/learning_remote_code_matcher_test.sv
